// ----- sv/npfr_pkg.sv -----
package npfr_pkg;

  // Register map (byte addresses), index = address / 4
  localparam int NUM_REGS      = 3;
  localparam int PADDR_W       = 4;
  localparam logic [1:0] REG_TIMEOUT = 2'd0;
  localparam logic [1:0] REG_START   = 2'd1;
  localparam logic [1:0] REG_END     = 2'd2;

  localparam logic [15:0] TIMEOUT_RST = 16'd1000;
  localparam logic [7:0]  START_RST   = 8'h02;
  localparam logic [7:0]  END_RST     = 8'h03;

  localparam int RAW_SIZE_DEF = 128;

  // Input opcodes
  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // Result kinds
  localparam logic KIND_DATA = 1'b0;
  localparam logic KIND_END  = 1'b1;

  // Frame end status
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_BAD_CRC  = 3'd1;
  localparam logic [2:0] ST_OVERFLOW = 3'd2;
  localparam logic [2:0] ST_TIMEOUT  = 3'd3;
  localparam logic [2:0] ST_RESTART  = 3'd4;

  localparam logic [7:0] CRC_POLY = 8'h8C;
  localparam logic [3:0] NIB_MASK = 4'hF;

  typedef struct packed {
    logic [15:0] timeout_ticks;
    logic [7:0]  start_code;
    logic [7:0]  end_code;
  } cfg_t;

  // Reflected CRC-8, LSB first, one byte
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc;
    for (int i = 0; i < 8; i++) begin
      if (c[0] ^ b[i]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// ----- sv/npfr_regs.sv -----
module npfr_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [npfr_pkg::PADDR_W-1:0]  paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  output npfr_pkg::cfg_t                cfg
);
  import npfr_pkg::*;

  logic        wr_en;
  logic [1:0]  reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.timeout_ticks <= TIMEOUT_RST;
      cfg.start_code    <= START_RST;
      cfg.end_code      <= END_RST;
    end else if (wr_en) begin
      case (reg_idx)
        REG_TIMEOUT: cfg.timeout_ticks <= pwdata[15:0];
        REG_START:   cfg.start_code    <= pwdata[7:0];
        REG_END:     cfg.end_code      <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_TIMEOUT: prdata = {16'd0, cfg.timeout_ticks};
      REG_START:   prdata = {24'd0, cfg.start_code};
      REG_END:     prdata = {24'd0, cfg.end_code};
      default:     prdata = 32'd0;
    endcase
  end

endmodule

// ----- sv/nibble_pair_frame_receiver.sv -----
// Channel   Handshake                 Payload
// -------   -----------------------   ---------------------------------------------
// input     in_valid / in_ready       opcode, rx_byte
// output    out_valid / out_ready     kind, data_byte, status, payload_length,
//                                     crc_received, crc_computed
// config    APB (psel/penable/...)    timeout_ticks @0x0, start_code @0x4, end_code @0x8
//
// One word per cycle while in_ready is high. Each accepted word is decoded
// combinationally against the frame state; any result lands in the output register on the same edge.
// in_ready is low only while a result sits unclaimed and out_ready is low.
// Reset (rst, synchronous) clears frame state, tick count and output valid,
// and loads the register defaults (1000 ticks, STX 0x02, ETX 0x03).
module nibble_pair_frame_receiver #(
  parameter int RAW_SIZE = npfr_pkg::RAW_SIZE_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  // config
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [npfr_pkg::PADDR_W-1:0]  paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  // input words
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          opcode,
  input  logic [7:0]                    rx_byte,
  // result words
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          kind,
  output logic [7:0]                    data_byte,
  output logic [2:0]                    status,
  output logic [6:0]                    payload_length,
  output logic [7:0]                    crc_received,
  output logic [7:0]                    crc_computed
);
  import npfr_pkg::*;

  // raw_count never exceeds RAW_SIZE: the frame is cut once it gets there
  localparam int RAW_W = $clog2(RAW_SIZE + 1);
  localparam logic [RAW_W-1:0] RAW_LIMIT = RAW_W'(RAW_SIZE);

  cfg_t cfg;

  npfr_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Frame state
  logic             in_frame, in_frame_next;
  logic [RAW_W-1:0] raw_count, raw_count_next;
  logic             nibble_pending, nibble_pending_next;
  logic [3:0]       high_half, high_half_next;
  logic             held_valid, held_valid_next;
  logic [7:0]       held_value, held_value_next;
  logic [7:0]       running_crc, running_crc_next;
  logic [6:0]       byte_count, byte_count_next;
  logic [15:0]      tick_count, tick_count_next;

  logic accept;
  logic emit_data;
  logic end_frame;
  logic restart;
  logic [2:0]  end_status;
  logic [7:0]  end_crc_rx;
  logic [15:0] tick_inc;
  logic        is_nibble;
  logic [7:0]  crc_val;
  logic        crc_valid;

  assign in_ready  = !out_valid || out_ready;
  assign accept    = in_valid && in_ready;
  assign tick_inc  = (tick_count == 16'hFFFF) ? tick_count : tick_count + 16'd1;
  // nibble code: upper half is the complement of the lower half
  assign is_nibble = (rx_byte[7:4] == (rx_byte[3:0] ^ NIB_MASK));

  always_comb begin
    in_frame_next       = in_frame;
    raw_count_next      = raw_count;
    nibble_pending_next = nibble_pending;
    high_half_next      = high_half;
    held_valid_next     = held_valid;
    held_value_next     = held_value;
    running_crc_next    = running_crc;
    byte_count_next     = byte_count;
    tick_count_next     = tick_count;
    emit_data  = 1'b0;
    end_frame  = 1'b0;
    restart    = 1'b0;
    end_status = ST_OK;
    end_crc_rx = 8'd0;
    crc_val    = nibble_pending ? {high_half, 4'd0} : held_value;
    crc_valid  = nibble_pending || held_valid;

    if (accept) begin
      if (opcode == OP_TICK) begin
        tick_count_next = tick_inc;
        if (tick_inc >= cfg.timeout_ticks) begin
          end_frame  = 1'b1;
          end_status = ST_TIMEOUT;
        end
      end else if (in_frame && raw_count >= RAW_LIMIT) begin
        end_frame  = 1'b1;
        end_status = ST_OVERFLOW;
      end else if (rx_byte == cfg.start_code) begin
        // restart reports the old frame only if one was open
        end_frame  = in_frame;
        end_status = ST_RESTART;
        restart    = 1'b1;
      end else if (!in_frame) begin
        // hunting: everything else is dropped
      end else if (rx_byte == cfg.end_code) begin
        end_frame = 1'b1;
        if (!crc_valid) begin
          end_status = ST_BAD_CRC;           // empty frame
        end else begin
          end_status = (running_crc == crc_val) ? ST_OK : ST_BAD_CRC;
          end_crc_rx = crc_val;
        end
      end else if (is_nibble) begin
        raw_count_next = raw_count + RAW_W'(1);
        if (!nibble_pending) begin
          // a new high nibble proves the held byte is payload
          if (held_valid) begin
            emit_data        = 1'b1;
            running_crc_next = crc8_byte(running_crc, held_value);
            if (byte_count != 7'h7F) begin
              byte_count_next = byte_count + 7'd1;
            end
            held_valid_next = 1'b0;
          end
          high_half_next      = rx_byte[7:4];
          nibble_pending_next = 1'b1;
        end else begin
          held_value_next     = {high_half, rx_byte[7:4]};
          held_valid_next     = 1'b1;
          nibble_pending_next = 1'b0;
        end
      end

      if (end_frame || restart) begin
        in_frame_next       = restart;
        raw_count_next      = restart ? RAW_W'(1) : '0;
        nibble_pending_next = 1'b0;
        held_valid_next     = 1'b0;
        running_crc_next    = 8'd0;
        byte_count_next     = 7'd0;
        tick_count_next     = 16'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame       <= 1'b0;
      raw_count      <= '0;
      nibble_pending <= 1'b0;
      held_valid     <= 1'b0;
      running_crc    <= 8'd0;
      byte_count     <= 7'd0;
      tick_count     <= 16'd0;
    end else begin
      in_frame       <= in_frame_next;
      raw_count      <= raw_count_next;
      nibble_pending <= nibble_pending_next;
      held_valid     <= held_valid_next;
      running_crc    <= running_crc_next;
      byte_count     <= byte_count_next;
      tick_count     <= tick_count_next;
    end
  end

  // held byte and high nibble are only read behind their flags
  always_ff @(posedge clk) begin
    high_half  <= high_half_next;
    held_value <= held_value_next;
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_data || end_frame) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (end_frame) begin
      kind           <= KIND_END;
      data_byte      <= 8'd0;
      status         <= end_status;
      payload_length <= byte_count;
      crc_received   <= end_crc_rx;
      crc_computed   <= running_crc;
    end else if (emit_data) begin
      kind           <= KIND_DATA;
      data_byte      <= held_value;
      status         <= ST_OK;
      payload_length <= 7'd0;
      crc_received   <= 8'd0;
      crc_computed   <= 8'd0;
    end
  end

endmodule
